### sv/ai2d_pkg.sv
`default_nettype none
package ai2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  // Determinant magnitude and divider remainder width.
  localparam int DEN_W     = 2 * VAL_W;
  // Numerator magnitude width: translation terms are a 64-bit difference
  // shifted by FRAC_BITS; linear terms are 32 bits shifted by 2*FRAC_BITS.
  localparam int NUM_W     = DEN_W + FRAC_BITS;
  localparam int QUO_W     = VAL_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int LANES     = 6;

  localparam logic [VAL_W-1:0] SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] SAT_NEG = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] ONE_FX  = VAL_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] nq;   // numerator bits still to shift in, quotient bits shifted out
    logic             neg;
    logic             big;  // quotient known to need more than QUO_W bits
  } ai2d_lane_t;

  typedef struct packed {
    ai2d_lane_t [LANES-1:0] lane;
    logic [DEN_W-1:0]       den;
    logic                   singular;
  } ai2d_div_t;

endpackage
`default_nettype wire

### sv/affine_2d_inverse_core.sv
// Inverts one 2D affine transform [a c e; b d f] per item, all terms signed
// Q16.16, returning the inverse in the same format with each quotient
// truncated toward zero and saturated to 32 bits (overflow flag). A zero
// determinant returns the identity with the singular flag. The pipeline
// takes one item per clock while the output is not stalled; its stages are an
// input register, multipliers, determinant, magnitudes and range check, a
// shared-divisor restoring divider that retires one quotient bit per
// stage for all six terms, and one output register. A stalled
// output holds its item while bubbles upstream still fill.
`default_nettype none
module affine_2d_inverse_core import ai2d_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // a, b, c, d, e, f: 32 bits each, from bit 0 up.
  input  wire logic [LANES*VAL_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // a, b, c, d, e, f: 32 bits each, from bit 0 up.
  output logic [LANES*VAL_W-1:0]      out_tdata,
  // singular (bit 0), overflow (bit 1).
  output logic [1:0]                  out_tuser
);

  logic      dv  [DIV_STEPS+1];
  logic      drdy[DIV_STEPS+1];
  ai2d_div_t dd  [DIV_STEPS+1];
  logic [LANES-1:0][VAL_W-1:0] val;

  ai2d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_a     (in_tdata[0*VAL_W +: VAL_W]),
    .in_b     (in_tdata[1*VAL_W +: VAL_W]),
    .in_c     (in_tdata[2*VAL_W +: VAL_W]),
    .in_d     (in_tdata[3*VAL_W +: VAL_W]),
    .in_e     (in_tdata[4*VAL_W +: VAL_W]),
    .in_f     (in_tdata[5*VAL_W +: VAL_W]),
    .out_valid(dv[0]),
    .out_ready(drdy[0]),
    .out_data (dd[0])
  );

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    ai2d_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dv[s]),
      .in_ready (drdy[s]),
      .in_data  (dd[s]),
      .out_valid(dv[s+1]),
      .out_ready(drdy[s+1]),
      .out_data (dd[s+1])
    );
  end

  ai2d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (dv[DIV_STEPS]),
    .in_ready    (drdy[DIV_STEPS]),
    .in_data     (dd[DIV_STEPS]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_val     (val),
    .out_singular(out_tuser[0]),
    .out_overflow(out_tuser[1])
  );

  assign out_tdata = val;

endmodule
`default_nettype wire

### sv/ai2d_front.sv
`default_nettype none
module ai2d_front import ai2d_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VAL_W-1:0]      in_a,
  input  wire logic [VAL_W-1:0]      in_b,
  input  wire logic [VAL_W-1:0]      in_c,
  input  wire logic [VAL_W-1:0]      in_d,
  input  wire logic [VAL_W-1:0]      in_e,
  input  wire logic [VAL_W-1:0]      in_f,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ai2d_div_t                  out_data
);

  localparam int NSTG = 5;

  typedef struct packed {
    logic signed [VAL_W-1:0] a, b, c, d, e, f;
  } st0_t;

  typedef struct packed {
    logic signed [DEN_W-1:0] ad, bc, cf, de, be, af;
    logic signed [VAL_W-1:0] a, b, c, d;
  } st1_t;

  typedef struct packed {
    logic signed [DEN_W:0]   det, n4, n5;
    logic signed [VAL_W-1:0] a, b, c, d;
  } st2_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [LANES-1:0]            neg;
    logic [DEN_W-1:0]            den;
    logic                        singular;
  } st3_t;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   rdy;
  st0_t s0_r, s0_nxt;
  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  ai2d_div_t s4_r, s4_nxt;

  assign rdy[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = s4_r;

  always_comb begin
    s0_nxt = '{a: in_a, b: in_b, c: in_c, d: in_d, e: in_e, f: in_f};

    s1_nxt.ad = s0_r.a * s0_r.d;
    s1_nxt.bc = s0_r.b * s0_r.c;
    s1_nxt.cf = s0_r.c * s0_r.f;
    s1_nxt.de = s0_r.d * s0_r.e;
    s1_nxt.be = s0_r.b * s0_r.e;
    s1_nxt.af = s0_r.a * s0_r.f;
    s1_nxt.a  = s0_r.a;
    s1_nxt.b  = s0_r.b;
    s1_nxt.c  = s0_r.c;
    s1_nxt.d  = s0_r.d;

    s2_nxt.det = {s1_r.ad[DEN_W-1], s1_r.ad} - {s1_r.bc[DEN_W-1], s1_r.bc};
    s2_nxt.n4  = {s1_r.cf[DEN_W-1], s1_r.cf} - {s1_r.de[DEN_W-1], s1_r.de};
    s2_nxt.n5  = {s1_r.be[DEN_W-1], s1_r.be} - {s1_r.af[DEN_W-1], s1_r.af};
    s2_nxt.a   = s1_r.a;
    s2_nxt.b   = s1_r.b;
    s2_nxt.c   = s1_r.c;
    s2_nxt.d   = s1_r.d;
  end

  // Sign and magnitude of every numerator and of the determinant.
  logic [VAL_W-1:0] mag_a, mag_b, mag_c, mag_d;
  logic [DEN_W:0]   mag_det, mag_n4, mag_n5;

  always_comb begin
    mag_a   = s2_r.a[VAL_W-1] ? (~s2_r.a + 1'b1) : s2_r.a;
    mag_b   = s2_r.b[VAL_W-1] ? (~s2_r.b + 1'b1) : s2_r.b;
    mag_c   = s2_r.c[VAL_W-1] ? (~s2_r.c + 1'b1) : s2_r.c;
    mag_d   = s2_r.d[VAL_W-1] ? (~s2_r.d + 1'b1) : s2_r.d;
    mag_det = s2_r.det[DEN_W] ? (~s2_r.det + 1'b1) : s2_r.det;
    mag_n4  = s2_r.n4[DEN_W] ? (~s2_r.n4 + 1'b1) : s2_r.n4;
    mag_n5  = s2_r.n5[DEN_W] ? (~s2_r.n5 + 1'b1) : s2_r.n5;

    s3_nxt.num[0] = {{(NUM_W-VAL_W){1'b0}}, mag_d} << (2 * FRAC_BITS);
    s3_nxt.num[1] = {{(NUM_W-VAL_W){1'b0}}, mag_b} << (2 * FRAC_BITS);
    s3_nxt.num[2] = {{(NUM_W-VAL_W){1'b0}}, mag_c} << (2 * FRAC_BITS);
    s3_nxt.num[3] = {{(NUM_W-VAL_W){1'b0}}, mag_a} << (2 * FRAC_BITS);
    s3_nxt.num[4] = {{(NUM_W-DEN_W){1'b0}}, mag_n4[DEN_W-1:0]} << FRAC_BITS;
    s3_nxt.num[5] = {{(NUM_W-DEN_W){1'b0}}, mag_n5[DEN_W-1:0]} << FRAC_BITS;

    // The result is negative when numerator and determinant signs differ.
    s3_nxt.neg[0] = s2_r.d[VAL_W-1] ^ s2_r.det[DEN_W];
    s3_nxt.neg[1] = (!s2_r.b[VAL_W-1] && (s2_r.b != '0)) ^ s2_r.det[DEN_W];
    s3_nxt.neg[2] = (!s2_r.c[VAL_W-1] && (s2_r.c != '0)) ^ s2_r.det[DEN_W];
    s3_nxt.neg[3] = s2_r.a[VAL_W-1] ^ s2_r.det[DEN_W];
    s3_nxt.neg[4] = s2_r.n4[DEN_W] ^ s2_r.det[DEN_W];
    s3_nxt.neg[5] = s2_r.n5[DEN_W] ^ s2_r.det[DEN_W];

    s3_nxt.den      = mag_det[DEN_W-1:0];
    s3_nxt.singular = (s2_r.det == '0);
  end

  // The upper numerator bits seed the remainder; if they already reach the
  // divisor, the quotient cannot fit and the lane saturates.
  always_comb begin
    s4_nxt.den      = s3_r.den;
    s4_nxt.singular = s3_r.singular;
    for (int i = 0; i < LANES; i++) begin
      s4_nxt.lane[i].rem = {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, s3_r.num[i][NUM_W-1:QUO_W]};
      s4_nxt.lane[i].nq  = s3_r.num[i][QUO_W-1:0];
      s4_nxt.lane[i].neg = s3_r.neg[i];
      s4_nxt.lane[i].big = (s4_nxt.lane[i].rem >= s3_r.den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_r <= s0_nxt;
    end
    if (rdy[1]) begin
      s1_r <= s1_nxt;
    end
    if (rdy[2]) begin
      s2_r <= s2_nxt;
    end
    if (rdy[3]) begin
      s3_r <= s3_nxt;
    end
    if (rdy[4]) begin
      s4_r <= s4_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/ai2d_div_stage.sv
`default_nettype none
module ai2d_div_stage import ai2d_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ai2d_div_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ai2d_div_t      out_data
);

  logic      v_r;
  ai2d_div_t d_r, d_nxt;
  logic [DEN_W:0] trial, diff;
  logic           ge;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  // One restoring division step per lane.
  always_comb begin
    d_nxt = in_data;
    trial = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      trial = {in_data.lane[i].rem, in_data.lane[i].nq[QUO_W-1]};
      diff  = trial - {1'b0, in_data.den};
      ge    = (trial >= {1'b0, in_data.den});
      d_nxt.lane[i].rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      d_nxt.lane[i].nq  = {in_data.lane[i].nq[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/ai2d_back.sv
`default_nettype none
module ai2d_back import ai2d_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire ai2d_div_t              in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LANES-1:0][VAL_W-1:0] out_val,
  output logic                        out_singular,
  output logic                        out_overflow
);

  logic                        v_r;
  logic [LANES-1:0][VAL_W-1:0] val_r, val_nxt;
  logic                        sing_r, ovf_r, ovf_nxt;
  logic [LANES-1:0]            sat;
  logic [QUO_W-1:0]            q;

  assign in_ready     = !v_r || out_ready;
  assign out_valid    = v_r;
  assign out_val      = val_r;
  assign out_singular = sing_r;
  assign out_overflow = ovf_r;

  always_comb begin
    q   = '0;
    sat = '0;
    for (int i = 0; i < LANES; i++) begin
      q = in_data.lane[i].nq;
      // A negative result may reach one step further than a positive one.
      sat[i] = in_data.lane[i].big ||
               (in_data.lane[i].neg ? (q > SAT_NEG) : q[QUO_W-1]);
      if (sat[i]) begin
        val_nxt[i] = in_data.lane[i].neg ? SAT_NEG : SAT_POS;
      end else begin
        val_nxt[i] = in_data.lane[i].neg ? (~q + 1'b1) : q;
      end
    end
    ovf_nxt = |sat;
    if (in_data.singular) begin
      val_nxt = '0;
      val_nxt[0] = ONE_FX;
      val_nxt[3] = ONE_FX;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      val_r  <= val_nxt;
      sing_r <= in_data.singular;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

### dv/affine_2d_inverse_checker.sv
`timescale 1ns / 1ps
module affine_2d_inverse_checker import ai2d_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [LANES*VAL_W-1:0] in_tdata,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [LANES*VAL_W-1:0] out_tdata,
  input  wire logic [1:0]             out_tuser,
  output int                          fail_count,
  output int                          pending_count
);

  typedef struct {
    logic [VAL_W-1:0] term [LANES];
    logic             singular;
    logic             overflow;
  } inverse_t;

  inverse_t inverse_q [$];

  // Truncating divide toward zero, saturated to 32 bits.
  function automatic logic [VAL_W-1:0] div_sat(input logic signed [127:0] num,
                                               input logic signed [127:0] den,
                                               inout logic ovf);
    logic signed [127:0] q;
    logic                neg;
    logic [127:0]        mag_n, mag_d, mag_q;
    neg   = num[127] ^ den[127];
    mag_n = num[127] ? -num : num;
    mag_d = den[127] ? -den : den;
    mag_q = mag_n / mag_d;
    if (!neg && mag_q > 128'h7FFF_FFFF) begin
      ovf = 1'b1;
      return SAT_POS;
    end
    if (neg && mag_q > 128'h8000_0000) begin
      ovf = 1'b1;
      return SAT_NEG;
    end
    q = neg ? -$signed(mag_q) : $signed(mag_q);
    return q[VAL_W-1:0];
  endfunction

  function automatic inverse_t invert(input logic [LANES*VAL_W-1:0] data);
    inverse_t            r;
    logic signed [127:0] v [LANES];
    logic signed [127:0] det;
    logic signed [127:0] num [LANES];
    logic                ovf;
    for (int k = 0; k < LANES; k++) v[k] = $signed(data[k*VAL_W +: VAL_W]);
    det = v[0] * v[3] - v[1] * v[2];
    ovf = 1'b0;
    if (det == 0) begin
      foreach (r.term[k]) r.term[k] = '0;
      r.term[0]  = ONE_FX;
      r.term[3]  = ONE_FX;
      r.singular = 1'b1;
      r.overflow = 1'b0;
      return r;
    end
    num[0] = v[3] <<< (2 * FRAC_BITS);
    num[1] = (-v[1]) <<< (2 * FRAC_BITS);
    num[2] = (-v[2]) <<< (2 * FRAC_BITS);
    num[3] = v[0] <<< (2 * FRAC_BITS);
    num[4] = (v[2] * v[5] - v[3] * v[4]) <<< FRAC_BITS;
    num[5] = (v[1] * v[4] - v[0] * v[5]) <<< FRAC_BITS;
    for (int k = 0; k < LANES; k++) r.term[k] = div_sat(num[k], det, ovf);
    r.singular = 1'b0;
    r.overflow = ovf;
    return r;
  endfunction

  assign pending_count = inverse_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    inverse_t want;
    if (rst_n && in_tvalid && in_tready) inverse_q.push_back(invert(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected item: tdata %h tuser %b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = inverse_q.pop_front();
        for (int k = 0; k < LANES; k++) begin
          if (out_tdata[k*VAL_W +: VAL_W] !== want.term[k]) begin
            $error("out_%s: expected %h, got %h", string'(8'("a" + k)), want.term[k],
                   out_tdata[k*VAL_W +: VAL_W]);
            fail_count++;
          end
        end
        if (out_tuser[0] !== want.singular) begin
          $error("singular: expected %b, got %b", want.singular, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ai2d_pkg::*;

  localparam int N_RANDOM    = 900;
  localparam int LATENCY     = 38;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [LANES*VAL_W-1:0] in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [LANES*VAL_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  int                     fail_count;
  int                     pending_count;
  int                     cycle_count = 0;
  bit                     long_hold = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  affine_2d_inverse_core uut (.*);

  affine_2d_inverse_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [VAL_W-1:0] rand_term();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return SAT_POS;
      2: return SAT_NEG;
      3: return 32'(int'($urandom_range(0, 8)) - 4) << FRAC_BITS;
      4: return 32'(int'($urandom_range(0, 200)) - 100);
      default: return 32'($signed($urandom()) >>> $urandom_range(8, 20));
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send(input logic [LANES*VAL_W-1:0] data, input bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_terms(input logic [VAL_W-1:0] a, b, c, d, e, f);
    send({f, e, d, c, b, a}, 1'b0);
  endtask

  initial begin
    logic [VAL_W-1:0] t [LANES];
    logic [LANES*VAL_W-1:0] w;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, zero matrix, singular rows, extremes and overflow cases.
    send_terms(ONE_FX, 0, 0, ONE_FX, 0, 0);
    send_terms(0, 0, 0, 0, 0, 0);
    send_terms(ONE_FX, 2 * ONE_FX, ONE_FX, 2 * ONE_FX, ONE_FX, ONE_FX);
    send_terms(SAT_POS, 0, 0, SAT_POS, SAT_POS, SAT_NEG);
    send_terms(SAT_NEG, 0, 0, SAT_NEG, SAT_NEG, SAT_POS);
    send_terms(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS, SAT_POS);
    send_terms(SAT_NEG, SAT_POS, SAT_POS, SAT_NEG, SAT_NEG, SAT_NEG);
    send_terms(1, 0, 0, 1, SAT_POS, SAT_NEG);
    send_terms(0, 1, 1, 0, 1, 1);
    send_terms(-ONE_FX, 0, 0, ONE_FX, 5 * ONE_FX, -3 * ONE_FX);
    send_terms(0, ONE_FX, -ONE_FX, 0, ONE_FX, ONE_FX);
    send_terms(2 * ONE_FX, 0, 0, 2 * ONE_FX, '1, '1);
    send_terms(1, 1, 0, 1, SAT_NEG, SAT_NEG);
    send_terms('1, 0, 0, '1, 0, 0);
    send_terms(3, 5, 7, 11, 13, 17);
    send_terms(SAT_NEG, 1, SAT_NEG, 1, 1, 1);

    // Sender pauses until every result has drained.
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) long_hold = 1'b1;
      foreach (t[k]) t[k] = rand_term();
      // Some singular items: second column a multiple of the first.
      if ($urandom_range(0, 9) == 0) begin
        t[2] = t[0] * 32'($urandom_range(0, 3));
        t[3] = t[1] * 32'($urandom_range(0, 3));
      end
      w = {t[5], t[4], t[3], t[2], t[1], t[0]};
      send(w, n < 200 || n > 500);
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
